// File: rtl/assert_macros.svh
// Assertion macros used by the spring force RTL.
// Depends on nothing; included by damped_spring_force, which checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define DSF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dsf assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define DSF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dsf assertion failed");

`endif

// File: rtl/dsf_pkg.sv
// Package for the damped spring force block: word types, register indexes, constants.
// Depends on nothing.
`timescale 1ns / 1ps

package dsf_pkg;

    localparam int DSF_COMP_BITS = 16;
    localparam int DSF_UFRAC     = 16;
    localparam int DSF_QW        = 17;
    localparam int DSF_OUT_SHIFT = 24;

    typedef enum logic [1:0] {
        REG_SPRING_K  = 2'd0,
        REG_DAMPING   = 2'd1,
        REG_REST_LEN  = 2'd2,
        REG_ENABLED   = 2'd3
    } t_dsf_reg;

    typedef struct packed {
        logic [47:0] pos_first;
        logic [47:0] pos_second;
        logic [47:0] vel_first;
        logic [47:0] vel_second;
        logic        first_pinned;
        logic        second_pinned;
    } t_dsf_in;

    typedef struct packed {
        logic signed [15:0] force_x;
        logic signed [15:0] force_y;
        logic signed [15:0] force_z;
        logic               add_to_first;
        logic               sub_from_second;
        logic               saturated;
    } t_dsf_out;

endpackage

// File: rtl/damped_spring_force.sv
// Damped spring force between two particles, fully pipelined.
// A new word is taken every cycle while the skid register is empty; the pipeline depth is
// mostly set by the square root (one result bit per stage, COMP_BITS + 1 stages) and the
// three parallel unit vector dividers (17 stages each). Back-pressure freezes the pipeline
// only once a result waits in the output register and a second one waits in the skid
// register behind it. Uses dsf_pkg, dsf_sqrt_pipe and dsf_div_pipe.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module damped_spring_force #(
    parameter int COMP_BITS = dsf_pkg::DSF_COMP_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_addr,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dsf_pkg::t_dsf_in  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dsf_pkg::t_dsf_out o_out_word
);

    localparam int C    = COMP_BITS;
    localparam int DW   = C + 1;
    localparam int SQW  = 2 * DW;
    localparam int NSQ  = DW;
    localparam int QW   = dsf_pkg::DSF_QW;
    localparam int UF   = dsf_pkg::DSF_UFRAC;
    localparam int UW   = QW + 1;
    localparam int PW   = UW + DW;
    localparam int DSW  = PW + 2;
    localparam int DOTW = DSW - UF;
    localparam int LTW  = ((DW + 1 > 16) ? DW + 1 : 16) + 1;
    localparam int SPW  = LTW + 16;
    localparam int DTW  = 16 + DOTW;
    localparam int FW   = ((SPW > DTW) ? SPW : DTW) + 1;
    localparam int FLO  = FW / 2;
    localparam int FHI  = FW - FLO;
    localparam int FPW  = UW + FW;
    localparam int OSH  = dsf_pkg::DSF_OUT_SHIFT;
    localparam int CW   = FPW - OSH;
    localparam int SR   = 2 + NSQ;
    localparam int SQ   = SR + QW;
    localparam int SU   = SQ + 1;
    localparam int SPP  = SU + 5;

    // Configuration registers.
    logic signed [15:0] r_k, r_damp, r_rest;
    logic               r_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_damp <= '0;
            r_rest <= '0;
            r_en   <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (dsf_pkg::t_dsf_reg'(i_cfg_addr))
                dsf_pkg::REG_SPRING_K: r_k    <= i_cfg_wdata;
                dsf_pkg::REG_DAMPING:  r_damp <= i_cfg_wdata;
                dsf_pkg::REG_REST_LEN: r_rest <= i_cfg_wdata;
                dsf_pkg::REG_ENABLED:  r_en   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic r_skid_v, r_out_v;
    logic w_adv;
    assign w_adv      = !r_skid_v;
    assign o_in_ready = w_adv;

    // Valid bits and the side data that travels alongside the arithmetic.
    logic              r_v   [0:SPP];
    logic              r_pa  [0:SPP];
    logic              r_pb  [0:SPP];
    logic signed [DW-1:0] r_d  [0:SQ][0:2];
    logic signed [DW-1:0] r_dv [0:SU][0:2];

    logic signed [DW-1:0] w_d  [0:2];
    logic signed [DW-1:0] w_dv [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i]  = $signed({i_in_word.pos_first[i*C+C-1], i_in_word.pos_first[i*C +: C]})
                    - $signed({i_in_word.pos_second[i*C+C-1], i_in_word.pos_second[i*C +: C]});
            w_dv[i] = $signed({i_in_word.vel_first[i*C+C-1], i_in_word.vel_first[i*C +: C]})
                    - $signed({i_in_word.vel_second[i*C+C-1], i_in_word.vel_second[i*C +: C]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= SPP; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v[0] <= i_in_valid;
            for (int s = 1; s <= SPP; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pa[0] <= i_in_word.first_pinned;
            r_pb[0] <= i_in_word.second_pinned;
            for (int s = 1; s <= SPP; s++) begin
                r_pa[s] <= r_pa[s-1];
                r_pb[s] <= r_pb[s-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_d[0][i]  <= w_d[i];
                r_dv[0][i] <= w_dv[i];
                for (int s = 1; s <= SQ; s++) begin
                    r_d[s][i] <= r_d[s-1][i];
                end
                for (int s = 1; s <= SU; s++) begin
                    r_dv[s][i] <= r_dv[s-1][i];
                end
            end
        end
    end

    // Squares and their sum.
    logic signed [SQW-1:0] w_sq [0:2];
    logic [SQW-1:0]        r_sq [0:2];
    logic [SQW-1:0]        r_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sq[i] = r_d[0][i] * r_d[0][i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= w_sq[i];
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    logic [DW-1:0] w_root;

    dsf_sqrt_pipe #(
        .RADW (SQW)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (r_sum),
        .o_root (w_root)
    );

    // Unit vector components by division of |d| by the length.
    logic [DW-1:0] w_mag [0:2];
    logic [QW-1:0] w_quo [0:2];
    logic [DW-1:0] w_len;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_d[SR][i][DW-1] ? DW'(-r_d[SR][i]) : DW'(r_d[SR][i]);
        end
    end

    dsf_div_pipe #(.LW(DW), .QW(QW)) u_div_x (
        .i_clk (i_clk), .i_en (w_adv), .i_mag (w_mag[0]), .i_len (w_root),
        .o_quo (w_quo[0]), .o_len (w_len)
    );
    dsf_div_pipe #(.LW(DW), .QW(QW)) u_div_y (
        .i_clk (i_clk), .i_en (w_adv), .i_mag (w_mag[1]), .i_len (w_root),
        .o_quo (w_quo[1]), .o_len ()
    );
    dsf_div_pipe #(.LW(DW), .QW(QW)) u_div_z (
        .i_clk (i_clk), .i_en (w_adv), .i_mag (w_mag[2]), .i_len (w_root),
        .o_quo (w_quo[2]), .o_len ()
    );

    // Force magnitude and its projection onto the unit vector.
    logic signed [UW-1:0]      w_u   [0:2];
    logic signed [UW-1:0]      r_u   [0:4][0:2];
    logic [DW-1:0]             r_len;
    logic signed [PW-1:0]      w_p   [0:2];
    logic signed [PW-1:0]      r_p   [0:2];
    logic signed [LTW-1:0]     w_lt;
    logic signed [SPW-1:0]     w_spr;
    logic signed [SPW-1:0]     r_spr [0:2];
    logic signed [DSW-1:0]     w_dsum;
    logic signed [DOTW-1:0]    r_dot;
    logic signed [DTW-1:0]     w_dt;
    logic signed [DTW-1:0]     r_dt;
    logic signed [FW-1:0]      w_f;
    logic signed [FW-1:0]      r_f;
    logic signed [UW+FLO:0]    w_plo [0:2];
    logic signed [UW+FHI-1:0]  w_phi [0:2];
    logic signed [UW+FLO:0]    r_plo [0:2];
    logic signed [UW+FHI-1:0]  r_phi [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_len == '0) begin
                w_u[i] = '0;
            end else if (r_d[SQ][i][DW-1]) begin
                w_u[i] = -$signed({1'b0, w_quo[i]});
            end else begin
                w_u[i] = $signed({1'b0, w_quo[i]});
            end
            w_p[i]   = r_u[0][i] * r_dv[SU][i];
            w_plo[i] = r_u[4][i] * $signed({1'b0, r_f[FLO-1:0]});
            w_phi[i] = r_u[4][i] * $signed(r_f[FW-1:FLO]);
        end
        w_lt   = $signed({1'b0, r_len}) - r_rest;
        w_spr  = w_lt * r_k;
        w_dsum = r_p[0] + r_p[1] + r_p[2];
        w_dt   = r_damp * r_dot;
        w_f    = -r_spr[2] - r_dt;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_len <= w_len;
            for (int i = 0; i < 3; i++) begin
                r_u[0][i] <= w_u[i];
                for (int s = 1; s < 5; s++) begin
                    r_u[s][i] <= r_u[s-1][i];
                end
                r_p[i]   <= w_p[i];
                r_plo[i] <= w_plo[i];
                r_phi[i] <= w_phi[i];
            end
            r_spr[0] <= w_spr;
            r_spr[1] <= r_spr[0];
            r_spr[2] <= r_spr[1];
            r_dot    <= w_dsum[DSW-1:UF];
            r_dt     <= w_dt;
            r_f      <= w_f;
        end
    end

    // Recombination, truncation, saturation and flags.
    logic signed [FPW-1:0] w_full [0:2];
    logic signed [CW-1:0]  w_c    [0:2];
    logic signed [15:0]    w_frc  [0:2];
    logic [2:0]            w_clip;
    logic                  w_kill;
    dsf_pkg::t_dsf_out     w_res;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_full[i] = (r_phi[i] <<< FLO) + r_plo[i];
            w_c[i]    = w_full[i][FPW-1:OSH];
            if (w_c[i] > $signed(CW'(32767))) begin
                w_frc[i]  = 16'sh7FFF;
                w_clip[i] = 1'b1;
            end else if (w_c[i] < -$signed(CW'(32768))) begin
                w_frc[i]  = -16'sh8000;
                w_clip[i] = 1'b1;
            end else begin
                w_frc[i]  = w_c[i][15:0];
                w_clip[i] = 1'b0;
            end
        end
        w_kill = !r_en || (r_pa[SPP] && r_pb[SPP]);
        if (w_kill) begin
            w_res = '0;
        end else begin
            w_res.force_x         = w_frc[0];
            w_res.force_y         = w_frc[1];
            w_res.force_z         = w_frc[2];
            w_res.add_to_first    = !r_pa[SPP];
            w_res.sub_from_second = !r_pb[SPP];
            w_res.saturated       = |w_clip;
        end
    end

    // Output register with a skid register behind it.
    dsf_pkg::t_dsf_out r_out, r_skid;
    logic w_load_out, w_load_skid, w_unskid;

    assign w_unskid    = r_skid_v && i_out_ready;
    assign w_load_out  = !r_skid_v && r_v[SPP] && (!r_out_v || i_out_ready);
    assign w_load_skid = !r_skid_v && r_v[SPP] && r_out_v && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_unskid) begin
                r_skid_v <= 1'b0;
            end else if (w_load_skid) begin
                r_skid_v <= 1'b1;
            end else if (w_load_out) begin
                r_out_v <= 1'b1;
            end else if (!r_skid_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_unskid) begin
            r_out <= r_skid;
        end else if (w_load_out) begin
            r_out <= w_res;
        end
        if (w_load_skid) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    `DSF_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `DSF_ASSERT_IMP(a_idle_no_force, i_clk, i_rst_n,
        o_out_valid && !o_out_word.add_to_first && !o_out_word.sub_from_second,
        o_out_word.force_x == 16'sd0 && o_out_word.force_y == 16'sd0 &&
        o_out_word.force_z == 16'sd0 && !o_out_word.saturated)
    `DSF_ASSERT_IMP(a_sat_at_rail, i_clk, i_rst_n, o_out_valid && o_out_word.saturated,
        o_out_word.force_x == 16'sh7FFF || o_out_word.force_x == -16'sh8000 ||
        o_out_word.force_y == 16'sh7FFF || o_out_word.force_y == -16'sh8000 ||
        o_out_word.force_z == 16'sh7FFF || o_out_word.force_z == -16'sh8000)
    `DSF_ASSERT_NXT(a_drain, i_clk, i_rst_n,
        o_out_valid && i_out_ready && !r_skid_v && !r_v[SPP], !o_out_valid)

endmodule

// File: rtl/dsf_sqrt_pipe.sv
// Pipelined integer square root, two radicand bits per register stage.
// Depends on nothing; used by damped_spring_force.
`timescale 1ns / 1ps

module dsf_sqrt_pipe #(
    parameter int RADW = 34
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [RADW-1:0]     i_rad,
    output logic [RADW/2-1:0]   o_root
);

    localparam int NR  = RADW / 2;
    localparam int RMW = NR + 2;

    logic [RADW-1:0] r_rad  [0:NR-1];
    logic [RMW-1:0]  r_rem  [0:NR-1];
    logic [NR-1:0]   r_root [0:NR-1];

    genvar j;
    generate
        for (j = 0; j < NR; j++) begin : g_stage
            logic [RADW-1:0] w_rad;
            logic [RMW-1:0]  w_rem;
            logic [NR-1:0]   w_root;
            logic [RMW+1:0]  w_acc;
            logic [RMW+1:0]  w_try;

            if (j == 0) begin : g_first
                assign w_rad  = i_rad;
                assign w_rem  = '0;
                assign w_root = '0;
            end else begin : g_next
                assign w_rad  = r_rad[j-1];
                assign w_rem  = r_rem[j-1];
                assign w_root = r_root[j-1];
            end

            assign w_acc = {w_rem, w_rad[RADW-1 -: 2]};
            assign w_try = {2'b00, w_root, 2'b01};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[j] <= {w_rad[RADW-3:0], 2'b00};
                    if (w_acc >= w_try) begin
                        r_rem[j]  <= RMW'(w_acc - w_try);
                        r_root[j] <= {w_root[NR-2:0], 1'b1};
                    end else begin
                        r_rem[j]  <= w_acc[RMW-1:0];
                        r_root[j] <= {w_root[NR-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_root[NR-1];

endmodule

// File: rtl/dsf_div_pipe.sv
// Pipelined restoring divider: (mag * 2^(QW-1)) / len, one quotient bit per stage.
// Depends on nothing; used by damped_spring_force. Requires mag <= len.
`timescale 1ns / 1ps

module dsf_div_pipe #(
    parameter int LW = 17,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [LW-1:0] i_mag,
    input  logic [LW-1:0] i_len,
    output logic [QW-1:0] o_quo,
    output logic [LW-1:0] o_len
);

    logic [LW-1:0] r_rem [0:QW-1];
    logic [QW-1:0] r_low [0:QW-1];
    logic [QW-1:0] r_q   [0:QW-1];
    logic [LW-1:0] r_len [0:QW-1];

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_stage
            logic [LW-1:0] w_rem;
            logic [QW-1:0] w_low;
            logic [QW-1:0] w_q;
            logic [LW-1:0] w_len;
            logic [LW:0]   w_sh;

            if (j == 0) begin : g_first
                assign w_rem = {1'b0, i_mag[LW-1:1]};
                assign w_low = {i_mag[0], {(QW-1){1'b0}}};
                assign w_q   = '0;
                assign w_len = i_len;
            end else begin : g_next
                assign w_rem = r_rem[j-1];
                assign w_low = r_low[j-1];
                assign w_q   = r_q[j-1];
                assign w_len = r_len[j-1];
            end

            assign w_sh = {w_rem, w_low[QW-1]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_low[j] <= {w_low[QW-2:0], 1'b0};
                    r_len[j] <= w_len;
                    if (w_sh >= {1'b0, w_len}) begin
                        r_rem[j] <= LW'(w_sh - {1'b0, w_len});
                        r_q[j]   <= {w_q[QW-2:0], 1'b1};
                    end else begin
                        r_rem[j] <= w_sh[LW-1:0];
                        r_q[j]   <= {w_q[QW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_q[QW-1];
    assign o_len = r_len[QW-1];

endmodule
